FILE: hdl/dfe_pkg.sv
package dfe_pkg;

  localparam int unsigned NUM_W   = 16;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned DATA_W  = 16;

  localparam logic [INDEX_W-1:0] REG_FIELD_NUMBER   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_MAX_LENGTH     = 3'd1;
  localparam logic [INDEX_W-1:0] REG_SEPARATOR      = 3'd2;
  localparam logic [INDEX_W-1:0] REG_STRIP_LEADING  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_STRIP_TRAILING = 3'd4;

  localparam logic [NUM_W-1:0]  FIELD_NUMBER_RST = 16'd1;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST   = 7'd64;
  localparam logic [BYTE_W-1:0] SEPARATOR_RST    = 8'd124;

  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'd0;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [NUM_W-1:0]  COUNT_SAT  = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REL,
    ST_FIN
  } dfe_state_t;

  typedef struct packed {
    logic accept;
    logic rel_step;
    logic fin;
  } dfe_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic rel_req;
    logic rel_last;
  } dfe_sts_t;

endpackage

FILE: hdl/dfe_ram.sv
module dfe_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/dfe_ctrl.sv
module dfe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dfe_pkg::dfe_sts_t sts,
  output dfe_pkg::dfe_cmd_t cmd
);

  dfe_pkg::dfe_state_t state_r;
  dfe_pkg::dfe_state_t state_nxt;
  logic                accept;

  assign in_ready = (state_r == dfe_pkg::ST_IDLE) && sts.slot_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dfe_pkg::ST_IDLE: begin
        if (accept && sts.rel_req) begin
          state_nxt = dfe_pkg::ST_REL;
        end
      end
      dfe_pkg::ST_REL: begin
        if (sts.slot_free && sts.rel_last) begin
          state_nxt = dfe_pkg::ST_FIN;
        end
      end
      dfe_pkg::ST_FIN: begin
        if (sts.slot_free) begin
          state_nxt = dfe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dfe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      dfe_pkg::ST_IDLE: cmd.accept   = accept;
      dfe_pkg::ST_REL:  cmd.rel_step = sts.slot_free;
      dfe_pkg::ST_FIN:  cmd.fin      = sts.slot_free;
      default:          cmd          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/dfe_datapath.sv
module dfe_datapath #(
  parameter int unsigned MAX_FIELD = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dfe_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [dfe_pkg::DATA_W-1:0]    cfg_wdata,
  input  logic [dfe_pkg::BYTE_W-1:0]    in_byte,
  input  dfe_pkg::dfe_cmd_t             cmd,
  output dfe_pkg::dfe_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_has_byte,
  output logic [dfe_pkg::BYTE_W-1:0]    out_field_byte,
  output logic                          out_done_res,
  output logic                          out_found,
  output logic [dfe_pkg::LEN_W-1:0]     out_copied_length
);

  localparam int unsigned AW = (MAX_FIELD > 1) ? $clog2(MAX_FIELD) : 1;
  localparam int unsigned CW = $clog2(MAX_FIELD + 1);
  localparam logic [dfe_pkg::LEN_W-1:0] MAX_LEN   = dfe_pkg::LEN_W'(MAX_FIELD);
  localparam logic [CW-1:0]             HELD_MAX  = CW'(MAX_FIELD);

  // configuration
  logic [dfe_pkg::NUM_W-1:0]  field_number_r;
  logic [dfe_pkg::LEN_W-1:0]  max_length_r;
  logic [dfe_pkg::BYTE_W-1:0] separator_r;
  logic                       strip_leading_r;
  logic                       strip_trailing_r;

  // scan state
  logic [dfe_pkg::NUM_W-1:0]  field_count_r, field_count_nxt;
  logic                       at_start_r, at_start_nxt;
  logic [dfe_pkg::LEN_W-1:0]  copied_r, copied_nxt;
  logic [CW-1:0]              held_r, held_nxt;
  logic                       sent_r, sent_nxt;

  // release walk
  logic [CW-1:0]              rel_cnt_r;
  logic [CW-1:0]              rel_idx_r;
  logic [dfe_pkg::BYTE_W-1:0] saved_r;

  // output register
  logic                       out_valid_r;
  logic                       out_has_byte_r;
  logic [dfe_pkg::BYTE_W-1:0] out_byte_r;
  logic                       out_done_r;
  logic                       out_found_r;
  logic [dfe_pkg::LEN_W-1:0]  out_len_r;

  logic [dfe_pkg::NUM_W-1:0]  fc_plus;
  logic [dfe_pkg::NUM_W-1:0]  fc_sat;
  logic [dfe_pkg::LEN_W-1:0]  limit;
  logic                       is_end;
  logic                       emit_done;
  logic                       emit_found;
  logic                       emit_byte;
  logic                       rel_req;
  logic                       hold_wr;
  logic                       rel_last;
  logic                       load_direct;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [CW-1:0]              rel_idx_inc;
  logic [dfe_pkg::BYTE_W-1:0] ram_rd_data;

  assign fc_plus     = field_count_r + 16'd1;
  assign fc_sat      = (field_count_r == dfe_pkg::COUNT_SAT) ? field_count_r : fc_plus;
  assign limit       = (max_length_r > MAX_LEN) ? MAX_LEN : max_length_r;
  assign is_end      = (in_byte == dfe_pkg::CHAR_NUL) || (in_byte == separator_r);
  assign rel_idx_inc = rel_idx_r + CW'(1);
  assign rel_last    = (rel_idx_inc == rel_cnt_r);

  always_comb begin
    field_count_nxt = field_count_r;
    at_start_nxt    = at_start_r;
    copied_nxt      = copied_r;
    held_nxt        = held_r;
    sent_nxt        = sent_r;
    emit_done       = 1'b0;
    emit_found      = 1'b0;
    emit_byte       = 1'b0;
    rel_req         = 1'b0;
    hold_wr         = 1'b0;
    if (is_end) begin
      if (!sent_r) begin
        field_count_nxt = fc_sat;
        if (fc_sat == field_number_r) begin
          emit_done  = 1'b1;
          emit_found = 1'b1;
          sent_nxt   = 1'b1;
        end else if (in_byte == dfe_pkg::CHAR_NUL) begin
          emit_done = 1'b1;
        end
        held_nxt     = '0;
        copied_nxt   = '0;
        at_start_nxt = 1'b1;
      end
      if (in_byte == dfe_pkg::CHAR_NUL) begin
        field_count_nxt = '0;
        at_start_nxt    = 1'b1;
        copied_nxt      = '0;
        held_nxt        = '0;
        sent_nxt        = 1'b0;
      end
    end else if (!sent_r &&
                 !(at_start_r && (in_byte == dfe_pkg::CHAR_SPACE) && strip_leading_r)) begin
      at_start_nxt = 1'b0;
      if ((field_count_r != dfe_pkg::COUNT_SAT) && (fc_plus == field_number_r) &&
          (copied_r < limit)) begin
        copied_nxt = copied_r + 7'd1;
        if (strip_trailing_r && (in_byte != dfe_pkg::CHAR_NUL) &&
            (in_byte <= dfe_pkg::CHAR_SPACE)) begin
          if (held_r < HELD_MAX) begin
            hold_wr  = 1'b1;
            held_nxt = held_r + CW'(1);
          end
        end else if (held_r != '0) begin
          rel_req  = 1'b1;
          held_nxt = '0;
        end else begin
          emit_byte = 1'b1;
        end
      end
    end
  end

  assign load_direct = cmd.accept && (emit_done || emit_byte);
  assign rd_en       = (cmd.accept && rel_req) || (cmd.rel_step && !rel_last);
  assign rd_addr     = cmd.accept ? '0 : rel_idx_inc[AW-1:0];

  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.rel_req   = rel_req;
  assign sts.rel_last  = rel_last;

  dfe_ram #(
    .WIDTH (dfe_pkg::BYTE_W),
    .DEPTH (MAX_FIELD)
  ) u_held (
    .clk     (clk),
    .wr_en   (cmd.accept && hold_wr),
    .wr_addr (held_r[AW-1:0]),
    .wr_data (in_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_number_r   <= dfe_pkg::FIELD_NUMBER_RST;
      max_length_r     <= dfe_pkg::MAX_LENGTH_RST;
      separator_r      <= dfe_pkg::SEPARATOR_RST;
      strip_leading_r  <= 1'b1;
      strip_trailing_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        dfe_pkg::REG_FIELD_NUMBER:   field_number_r   <= cfg_wdata;
        dfe_pkg::REG_MAX_LENGTH:     max_length_r     <= cfg_wdata[dfe_pkg::LEN_W-1:0];
        dfe_pkg::REG_SEPARATOR:      separator_r      <= cfg_wdata[dfe_pkg::BYTE_W-1:0];
        dfe_pkg::REG_STRIP_LEADING:  strip_leading_r  <= cfg_wdata[0];
        dfe_pkg::REG_STRIP_TRAILING: strip_trailing_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_count_r <= '0;
      at_start_r    <= 1'b1;
      copied_r      <= '0;
      held_r        <= '0;
      sent_r        <= 1'b0;
      rel_cnt_r     <= '0;
      rel_idx_r     <= '0;
    end else begin
      if (cmd.accept) begin
        field_count_r <= field_count_nxt;
        at_start_r    <= at_start_nxt;
        copied_r      <= copied_nxt;
        held_r        <= held_nxt;
        sent_r        <= sent_nxt;
        if (rel_req) begin
          // snapshot the run length, walk it from entry zero
          rel_cnt_r <= held_r;
          rel_idx_r <= '0;
        end
      end else if (cmd.rel_step) begin
        rel_idx_r <= rel_idx_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && rel_req) begin
      saved_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_direct || cmd.rel_step || cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      out_has_byte_r <= emit_byte;
      out_byte_r     <= emit_byte ? in_byte : dfe_pkg::CHAR_NUL;
      out_done_r     <= emit_done;
      out_found_r    <= emit_found;
      out_len_r      <= emit_found ? copied_r : '0;
    end else if (cmd.rel_step || cmd.fin) begin
      out_has_byte_r <= 1'b1;
      out_byte_r     <= cmd.fin ? saved_r : ram_rd_data;
      out_done_r     <= 1'b0;
      out_found_r    <= 1'b0;
      out_len_r      <= '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_has_byte      = out_has_byte_r;
  assign out_field_byte    = out_byte_r;
  assign out_done_res      = out_done_r;
  assign out_found         = out_found_r;
  assign out_copied_length = out_len_r;

endmodule

FILE: hdl/delimited_field_extractor.sv
// Output: a direct result is registered in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output drains; a byte that releases a
// held run of n bytes keeps the block busy while the run is sent from the held-byte
// memory via its single registered read port, one entry per cycle unless stalled.
// Reset: synchronous, active low; control, configuration, scan and out_valid
// registers reset, scanning restarts; held-byte memory and the rest are left as is.
module delimited_field_extractor #(
  parameter int unsigned MAX_FIELD = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dfe_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [dfe_pkg::DATA_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dfe_pkg::BYTE_W-1:0]    in_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_has_byte,
  output logic [dfe_pkg::BYTE_W-1:0]    out_field_byte,
  output logic                          out_done_res,
  output logic                          out_found,
  output logic [dfe_pkg::LEN_W-1:0]     out_copied_length
);

  dfe_pkg::dfe_cmd_t cmd;
  dfe_pkg::dfe_sts_t sts;

  dfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dfe_datapath #(
    .MAX_FIELD (MAX_FIELD)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_byte           (in_byte),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_has_byte      (out_has_byte),
    .out_field_byte    (out_field_byte),
    .out_done_res      (out_done_res),
    .out_found         (out_found),
    .out_copied_length (out_copied_length)
  );

endmodule
